FILE: hw/rtl/tbrl_pkg.sv
// ---------------------------------------------------------------------------
// tbrl_pkg: shared types and constants of the token bucket rate limiter
// Item layouts, register indexes, reset values and the window length table.
// ---------------------------------------------------------------------------
package tbrl_pkg;

  // storage and loop sizes
  localparam int unsigned KEYS_DEF  = 64;
  localparam int unsigned KEY_W     = 6;
  localparam int unsigned KEY_SPAN  = 64;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned WIN_W     = 22;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LVL_W     = 38;
  localparam int unsigned ADD_W     = 48;
  localparam int unsigned MUL_STEPS = 16;
  localparam int unsigned DIV_STEPS = 22;
  localparam int unsigned CNT_W     = 5;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  // configuration reset values
  localparam logic [CAP_W-1:0] CAP_RST = 16'd10;
  localparam logic [1:0]       WIN_RST = 2'd1;

  // window unit codes
  localparam logic [1:0] UNIT_MS   = 2'd0;
  localparam logic [1:0] UNIT_SEC  = 2'd1;
  localparam logic [1:0] UNIT_MIN  = 2'd2;
  localparam logic [1:0] UNIT_HOUR = 2'd3;

  // input item
  typedef struct packed {
    logic [KEY_W-1:0]  key_index;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  // result item
  typedef struct packed {
    logic             allowed;
    logic [WIN_W-1:0] retry_after_ms;
  } res_t;

  // window length in milliseconds
  function automatic logic [WIN_W-1:0] window_len(input logic [1:0] unit);
    logic [WIN_W-1:0] len;
    case (unit)
      UNIT_MS:   len = 22'd1;
      UNIT_SEC:  len = 22'd1000;
      UNIT_MIN:  len = 22'd60000;
      UNIT_HOUR: len = 22'd3600000;
      default:   len = 22'd3600000;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/token_bucket_rate_limiter.sv
// ---------------------------------------------------------------------------
// token_bucket_rate_limiter: per-key token bucket policer
// Refills a key's bucket by elapsed time times capacity, takes one token
// when there is one, and reports the ceiling wait until the next token.
// ---------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  request   start_i, req_i (key_index, now_ms)        start_i && !busy_o
//  result    done_o, res_o (allowed, retry_after_ms)   done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i          cfg_we_i, no wait
//
//  An item goes through one bucket read, 16 steps of the bit-serial multiplier,
//  22 steps of the bit-serial divider and five further steps (elapsed
//  time, sum, clip, token take, deficit) before its result strobe. One
//  item is in flight at a time; a new item may be accepted in the cycle
//  the result strobe is high.
//  Reset clears the configuration to its defaults and marks all buckets
//  unused. The receiver cannot stall: each result is shown once.
//
module token_bucket_rate_limiter #(
  parameter int unsigned KEYS = tbrl_pkg::KEYS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  tbrl_pkg::req_t            req_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [tbrl_pkg::CAP_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output tbrl_pkg::res_t            res_o
);

  // only the first 64 keys can ever be addressed
  localparam int unsigned DEPTH = (KEYS < tbrl_pkg::KEY_SPAN) ? KEYS : tbrl_pkg::KEY_SPAN;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = tbrl_pkg::KEY_W + 17;
  localparam int unsigned CW    = tbrl_pkg::CAP_W;
  localparam int unsigned WW    = tbrl_pkg::WIN_W;
  localparam int unsigned TW    = tbrl_pkg::TIME_W;
  localparam int unsigned LW    = tbrl_pkg::LVL_W;
  localparam int unsigned AW    = tbrl_pkg::ADD_W;

  // sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_DIFF = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_SUM  = 4'd4;
  localparam logic [3:0] ST_CLIP = 4'd5;
  localparam logic [3:0] ST_TAKE = 4'd6;
  localparam logic [3:0] ST_DEF  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;

  // control state
  logic [3:0]                  state_q, state_d;
  logic [tbrl_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEPTH-1:0]            valid_q;
  logic                        done_q;
  logic [CW-1:0]               cap_cfg_q;
  logic [1:0]                  win_cfg_q;

  // datapath registers
  logic [IW-1:0]  key_q;
  logic [TW-1:0]  now_q;
  logic [CW-1:0]  cap_q;
  logic [CW-1:0]  capsh_q;
  logic [WW-1:0]  win_q;
  logic           new_q;
  logic [LW-1:0]  rd_lvl_q;
  logic [TW-1:0]  rd_last_q;
  logic [AW-1:0]  mcand_a_q;
  logic [LW-1:0]  mcand_w_q;
  logic [AW-1:0]  acc_add_q;
  logic [LW-1:0]  acc_full_q;
  logic [AW:0]    sum_q;
  logic [LW-1:0]  lvl_q;
  logic           ok_q;
  logic [WW-1:0]  dvd_q;
  logic [CW-1:0]  rem_q;
  tbrl_pkg::res_t res_q;

  // bucket store: level above last timestamp
  logic [LW+TW-1:0] mem_q [DEPTH];

  logic           accept;
  logic [RW-1:0]  key_red;
  logic [TW-1:0]  elapsed;
  logic [LW-1:0]  lvl_take;
  logic [CW:0]    div_trial;
  logic           div_ge;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // key reduced modulo KEYS by shifted compare and subtract
  always_comb begin
    key_red = RW'(req_i.key_index);
    for (int j = tbrl_pkg::KEY_W - 1; j >= 0; j--) begin
      if (key_red >= (RW'(KEYS) << j)) begin
        key_red = key_red - (RW'(KEYS) << j);
      end
    end
  end

  // elapsed time wraps modulo 2^32
  assign elapsed = now_q - rd_last_q;

  // level after taking one token when there is one
  assign lvl_take = (lvl_q >= LW'(win_q)) ? (lvl_q - LW'(win_q)) : lvl_q;

  // one restoring division step
  assign div_trial = {rem_q, dvd_q[WW-1]};
  assign div_ge    = (div_trial >= (CW+1)'(cap_q));

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: begin
        state_d = ST_MUL;
        cnt_d   = tbrl_pkg::CNT_W'(tbrl_pkg::MUL_STEPS - 1);
      end
      ST_MUL: begin
        if (cnt_q == '0) state_d = ST_SUM;
        else cnt_d = cnt_q - tbrl_pkg::CNT_W'(1);
      end
      ST_SUM:  state_d = ST_CLIP;
      ST_CLIP: state_d = ST_TAKE;
      ST_TAKE: state_d = ST_DEF;
      ST_DEF: begin
        state_d = ST_DIV;
        cnt_d   = tbrl_pkg::CNT_W'(tbrl_pkg::DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_IDLE;
        else cnt_d = cnt_q - tbrl_pkg::CNT_W'(1);
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      done_q    <= 1'b0;
      cap_cfg_q <= tbrl_pkg::CAP_RST;
      win_cfg_q <= tbrl_pkg::WIN_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == ST_DIV) && (cnt_q == '0);
      if (state_q == ST_TAKE) begin
        valid_q[key_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tbrl_pkg::REG_CAPACITY: cap_cfg_q <= cfg_wdata_i;
          tbrl_pkg::REG_WINDOW:   win_cfg_q <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // bucket store read and write
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      {rd_lvl_q, rd_last_q} <= mem_q[key_q];
    end
    if (state_q == ST_TAKE) begin
      mem_q[key_q] <= {lvl_take, now_q};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_q <= key_red[IW-1:0];
          now_q <= req_i.now_ms;
          cap_q <= (cap_cfg_q == '0) ? CW'(1) : cap_cfg_q;
          win_q <= tbrl_pkg::window_len(win_cfg_q);
        end
      end
      ST_READ: new_q <= !valid_q[key_q];
      // elapsed time, zero on first access
      ST_DIFF: begin
        mcand_a_q  <= new_q ? '0 : AW'(elapsed);
        mcand_w_q  <= LW'(win_q);
        capsh_q    <= cap_q;
        acc_add_q  <= '0;
        acc_full_q <= '0;
      end
      // shift-add over the capacity bits: refill and full level
      ST_MUL: begin
        if (capsh_q[0]) begin
          acc_add_q  <= acc_add_q + mcand_a_q;
          acc_full_q <= acc_full_q + mcand_w_q;
        end
        mcand_a_q <= mcand_a_q << 1;
        mcand_w_q <= mcand_w_q << 1;
        capsh_q   <= capsh_q >> 1;
      end
      ST_SUM:  sum_q <= (AW+1)'(rd_lvl_q) + (AW+1)'(acc_add_q);
      // clip at a full bucket, a fresh bucket starts full
      ST_CLIP: begin
        if (new_q || (sum_q >= (AW+1)'(acc_full_q))) lvl_q <= acc_full_q;
        else lvl_q <= sum_q[LW-1:0];
      end
      ST_TAKE: begin
        ok_q  <= (lvl_q >= LW'(win_q));
        lvl_q <= lvl_take;
      end
      // deficit to one whole token
      ST_DEF: begin
        if (lvl_q < LW'(win_q)) dvd_q <= win_q - lvl_q[WW-1:0];
        else dvd_q <= '0;
        rem_q <= '0;
      end
      ST_DIV: begin
        dvd_q <= {dvd_q[WW-2:0], div_ge};
        rem_q <= div_ge ? CW'(div_trial - (CW+1)'(cap_q)) : div_trial[CW-1:0];
        if (cnt_q == '0) begin
          res_q.allowed        <= ok_q;
          res_q.retry_after_ms <= {dvd_q[WW-2:0], div_ge} +
            WW'(div_ge ? (CW'(div_trial - (CW+1)'(cap_q)) != '0)
                       : (div_trial[CW-1:0] != '0));
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/tbrl_chk.sv
// ---------------------------------------------------------------------------
// tbrl_chk: port checks of the token bucket rate limiter
// Watches the request and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module tbrl_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input tbrl_pkg::res_t res_o
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted item did not raise busy");

  // no result straight after acceptance
  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !done_o)
    else $error("result too soon after acceptance");

  // a result ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result outside a busy period");

  // the strobe lasts one cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // a rejected item always has a wait
  a_reject_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.allowed |-> res_o.retry_after_ms != '0)
    else $error("rejected item with zero wait");

endmodule

bind token_bucket_rate_limiter tbrl_chk u_tbrl_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
